[hw/rtl/erq_pkg.sv]
// Shared types and constants for the elevator request queue.
`default_nettype none

package erq_pkg;

  localparam int FLOOR_W = 8;
  localparam int COUNT_OUT_W = 5;

  // Item kinds
  localparam logic FUNC_REQUEST  = 1'b0;
  localparam logic FUNC_POSITION = 1'b1;

  // Configuration register indexes
  localparam logic CFG_LOWEST  = 1'b0;
  localparam logic CFG_HIGHEST = 1'b1;

  typedef logic [FLOOR_W-1:0] floor_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic push;    // shift toward the tail, new floor enters at the head
    logic pop;     // shift toward the head, head drops out
    logic search;  // capture this cell's match against the key
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/erq_cell.sv]
// One entry of the request chain: holds a floor, shifts, and matches it.
`default_nettype none

module erq_cell (
  input  wire                  clk,
  input  erq_pkg::cell_ctrl_t  ctrl,
  input  erq_pkg::floor_t      key,
  input  wire                  live,
  input  erq_pkg::floor_t      left_floor,
  input  erq_pkg::floor_t      right_floor,
  output erq_pkg::floor_t      floor_q,
  output logic                 hit
);
  import erq_pkg::*;

  floor_t floor_r, floor_nxt;
  logic   hit_r, hit_nxt;

  always_comb begin
    floor_nxt = floor_r;
    if (ctrl.push) begin
      floor_nxt = left_floor;
    end else if (ctrl.pop) begin
      floor_nxt = right_floor;
    end
  end

  assign hit_nxt = ctrl.search ? (live && (floor_r == key)) : hit_r;

  always_ff @(posedge clk) begin
    floor_r <= floor_nxt;
    hit_r   <= hit_nxt;
  end

  assign floor_q = floor_r;
  assign hit     = hit_r;

endmodule

`default_nettype wire

[hw/rtl/elevator_request_queue.sv]
// Top level of the elevator request queue: control, counters and the cell chain.
// Usage:
//   Input channel: drive in_func and in_floor_number and raise start while
//   busy is low; the request is taken at that clock edge. in_func selects a
//   floor request or a car position report.
//   Result channel: exactly one result per request. out_valid is high for a
//   single cycle with all out_ fields; the receiver cannot stall it, so it
//   must sample in that cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 lowest floor,
//   1 highest floor) and cfg_data. cfg_ready is always high; write only while
//   the block is idle.
//   Timing: a request is captured while busy is low, then busy stays high
//   through the search of the chain and the apply step. Its result shows on
//   the cycle after the apply step. A new request can be taken in that same
//   cycle; none is taken while one is in progress, and the pace is set by
//   the registered per-cell match followed by the registered reduce-and-shift
//   step.
//   Reset: synchronous, active low. Clears the list count, the car position,
//   the limits (0 and 255) and the strobe. Floor cells are not cleared: a
//   cell is only read while it lies below the count.
`default_nettype none

module elevator_request_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // request channel
  input  wire                   start,
  output logic                  busy,
  input  wire                   in_func,
  input  erq_pkg::floor_t       in_floor_number,
  // result channel
  output logic                  out_valid,
  output logic                  out_request_taken,
  output logic                  out_open_door,
  output logic                  out_go_idle,
  output logic                  out_target_valid,
  output erq_pkg::floor_t       out_target_floor,
  output logic [4:0]            out_pending_count,
  output erq_pkg::floor_t       out_car_floor,
  // configuration
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  erq_pkg::floor_t       cfg_data
);
  import erq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  floor_t            pos_r, pos_nxt;
  floor_t            lowest_r, lowest_nxt;
  floor_t            highest_r, highest_nxt;

  // Captured request
  logic              func_r, func_nxt;
  floor_t            key_r, key_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  logic              taken_r, taken_nxt;
  logic              door_r, door_nxt;
  logic              idle_r, idle_nxt;
  logic              tvalid_r, tvalid_nxt;
  floor_t            target_r, target_nxt;
  logic [CNT_W-1:0]  cnt_out_r, cnt_out_nxt;
  floor_t            car_r, car_nxt;

  logic              accept;
  logic              apply;
  logic              searching;
  floor_t            clamped;
  cell_ctrl_t        ctrl;

  // Chain
  floor_t            cell_floor [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] cell_live;

  logic              dup;
  logic              full;
  logic              empty;
  logic              at_head;
  logic              push;
  logic              pop;

  logic [CNT_W+4:0]  cnt_ext;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Clamp down to the top limit, then up to the bottom limit (bottom wins
  // when the limits are inverted).
  always_comb begin
    clamped = in_floor_number;
    if (clamped > highest_r) begin
      clamped = highest_r;
    end
    if (clamped < lowest_r) begin
      clamped = lowest_r;
    end
  end

  // ---------------------------------------------------------------
  // State machine: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State machine: outputs
  always_comb begin
    busy      = 1'b1;
    searching = 1'b0;
    apply     = 1'b0;
    case (state_r)
      ST_IDLE:   busy      = 1'b0;
      ST_SEARCH: searching = 1'b1;
      ST_APPLY:  apply     = 1'b1;
      default:   busy      = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------
  // Apply step: reduce the registered matches and decide the shift
  // ---------------------------------------------------------------
  assign dup     = |cell_hit;
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign at_head = (cell_floor[0] == key_r);

  assign push = apply && (func_r == FUNC_REQUEST) && !full && !dup;
  assign pop  = apply && (func_r == FUNC_POSITION) && !empty && at_head;

  assign ctrl.push   = push;
  assign ctrl.pop    = pop;
  assign ctrl.search = searching;

  always_comb begin
    func_nxt    = func_r;
    key_nxt     = key_r;
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;

    // Capture the request; requests are clamped on the way in
    if (accept) begin
      func_nxt = in_func;
      key_nxt  = (in_func == FUNC_REQUEST) ? clamped : in_floor_number;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOWEST:  lowest_nxt  = cfg_data;
        CFG_HIGHEST: highest_nxt = cfg_data;
        default:     lowest_nxt  = lowest_r;
      endcase
    end

    if (push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop) begin
      count_nxt = count_r - CNT_W'(1);
    end

    if (apply && (func_r == FUNC_POSITION)) begin
      pos_nxt = key_r;
    end
  end

  // Result: fill in during the apply step, strobe on the next cycle
  always_comb begin
    out_valid_nxt = apply;
    taken_nxt     = taken_r;
    door_nxt      = door_r;
    idle_nxt      = idle_r;
    tvalid_nxt    = tvalid_r;
    target_nxt    = target_r;
    cnt_out_nxt   = cnt_out_r;
    car_nxt       = car_r;
    if (apply) begin
      taken_nxt   = push;
      door_nxt    = pop;
      idle_nxt    = (func_r == FUNC_POSITION) && empty;
      tvalid_nxt  = (func_r == FUNC_POSITION) && !empty && !at_head;
      target_nxt  = ((func_r == FUNC_POSITION) && !empty && !at_head) ?
                    cell_floor[0] : '0;
      cnt_out_nxt = count_nxt;
      car_nxt     = pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      lowest_r    <= '0;
      highest_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    taken_r   <= taken_nxt;
    door_r    <= door_nxt;
    idle_r    <= idle_nxt;
    tvalid_r  <= tvalid_nxt;
    target_r  <= target_nxt;
    cnt_out_r <= cnt_out_nxt;
    car_r     <= car_nxt;
  end

  // ---------------------------------------------------------------
  // Cell chain: head at index 0, new floors enter there and push the
  // rest toward the tail; a pop pulls every cell one step toward the head.
  // ---------------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    floor_t left_floor;
    floor_t right_floor;

    if (i == 0) begin : g_head
      assign left_floor = key_r;
    end else begin : g_body
      assign left_floor = cell_floor[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_floor = cell_floor[i];
    end else begin : g_inner
      assign right_floor = cell_floor[i+1];
    end

    // Only cells below the count hold listed floors
    assign cell_live[i] = (count_r > CNT_W'(i));

    erq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key_r),
      .live        (cell_live[i]),
      .left_floor  (left_floor),
      .right_floor (right_floor),
      .floor_q     (cell_floor[i]),
      .hit         (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------
  assign cnt_ext = {5'b0, cnt_out_r};

  assign out_valid         = out_valid_r;
  assign out_request_taken = taken_r;
  assign out_open_door     = door_r;
  assign out_go_idle       = idle_r;
  assign out_target_valid  = tvalid_r;
  assign out_target_floor  = target_r;
  assign out_pending_count = cnt_ext[4:0];
  assign out_car_floor     = car_r;

endmodule

`default_nettype wire
